// ===== sv/scan_timing_statistics_unit_macros.svh =====
// ----------------------------------------------------------------------------
// scan timing statistics unit assertion macros
// clocked on clk and disabled while arst_n is low; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef SCAN_TIMING_STATISTICS_UNIT_MACROS_SVH
`define SCAN_TIMING_STATISTICS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define STSU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define STSU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define STSU_ASSERT(lbl, prop)
`define STSU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/stsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsu_pkg
// widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package stsu_pkg;

	localparam int MAX_SAMPLES   = 65536;
	localparam int TIME_BITS     = 24;

	localparam int TIME_W        = 24;
	localparam int CNT_W         = 17;
	localparam int SUM_W         = 40;
	localparam int SQ_W          = 64;
	localparam int MUL_W         = 32;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int D_W           = 81;
	localparam int NSQ_W         = 33;
	localparam int STEP_W        = 7;
	localparam int MOP_W         = 3;

	localparam int MUL_OPS       = 6;
	localparam int DIV_STEPS     = D_W;
	localparam int SQRT_STEPS    = SQ_W / 2;

	localparam int JITTER_SCALE  = 20;
	localparam int OVERRUN_SCALE = 1000;
	localparam int JIT_W         = 29;
	localparam int OVR_W         = 27;

	localparam logic [TIME_W-1:0] TIME_MASK    = TIME_W'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [TIME_W-1:0] PERIOD_RESET = 24'd250000;
	localparam logic [SQ_W-1:0]   SQRT_BIT0    = 64'h4000_0000_0000_0000;

	// partial products of the variance numerator and of n squared
	typedef enum logic [MOP_W-1:0] {
		MOP_NSQ_LO = 3'd0,  // n * sumsq[31:0]
		MOP_NSQ_HI = 3'd1,  // n * sumsq[63:32]
		MOP_LL     = 3'd2,  // sum_lo * sum_lo
		MOP_HL     = 3'd3,  // sum_hi * sum_lo, counted twice
		MOP_HH     = 3'd4,  // sum_hi * sum_hi
		MOP_NN     = 3'd5   // n * n
	} mop_t;

	typedef enum logic [5:0] {
		ST_ACC  = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIVM = 6'b000100,
		ST_DIVV = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic acc_en;
		logic snap;
		logic mul_issue;
		mop_t mul_op;
		logic div_load_mean;
		logic div_load_var;
		logic div_step;
		logic sqrt_load;
		logic sqrt_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

// ===== sv/stsu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "scan_timing_statistics_unit_macros.svh"
// ----------------------------------------------------------------------------
// stsu_ctrl
// sequencer: accumulation, partial products, two divisions, square root
// ----------------------------------------------------------------------------
module stsu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last,
	output logic           in_ready,
	input  stsu_pkg::stat_t st,
	output stsu_pkg::cmd_t  cmd
);

	stsu_pkg::state_t                state_q, state_d;
	logic [stsu_pkg::STEP_W-1:0]     cnt_q, cnt_d;
	logic                            accept;

	assign in_ready = (state_q == stsu_pkg::ST_ACC);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + stsu_pkg::STEP_W'(1);
		cmd     = '0;
		case (state_q)
			stsu_pkg::ST_ACC: begin
				cnt_d      = '0;
				cmd.acc_en = accept;
				cmd.snap   = accept && last;
				if (accept && last) begin
					state_d = stsu_pkg::ST_MUL;
				end
			end
			stsu_pkg::ST_MUL: begin
				cmd.mul_issue = (cnt_q < stsu_pkg::STEP_W'(stsu_pkg::MUL_OPS));
				cmd.mul_op    = stsu_pkg::mop_t'(cnt_q[stsu_pkg::MOP_W-1:0]);
				// last product is folded in on this edge
				if (cnt_q == stsu_pkg::STEP_W'(stsu_pkg::MUL_OPS)) begin
					state_d = stsu_pkg::ST_DIVM;
					cnt_d   = '0;
				end
			end
			stsu_pkg::ST_DIVM: begin
				cmd.div_load_mean = (cnt_q == '0);
				cmd.div_step      = (cnt_q != '0);
				if (cnt_q == stsu_pkg::STEP_W'(stsu_pkg::DIV_STEPS)) begin
					state_d = stsu_pkg::ST_DIVV;
					cnt_d   = '0;
				end
			end
			stsu_pkg::ST_DIVV: begin
				cmd.div_load_var = (cnt_q == '0);
				cmd.div_step     = (cnt_q != '0);
				if (cnt_q == stsu_pkg::STEP_W'(stsu_pkg::DIV_STEPS)) begin
					state_d = stsu_pkg::ST_SQRT;
					cnt_d   = '0;
				end
			end
			stsu_pkg::ST_SQRT: begin
				cmd.sqrt_load = (cnt_q == '0);
				cmd.sqrt_step = (cnt_q != '0);
				if (cnt_q == stsu_pkg::STEP_W'(stsu_pkg::SQRT_STEPS)) begin
					state_d = stsu_pkg::ST_OUT;
					cnt_d   = '0;
				end
			end
			stsu_pkg::ST_OUT: begin
				cnt_d        = '0;
				cmd.out_load = !st.out_busy;
				if (!st.out_busy) begin
					state_d = stsu_pkg::ST_ACC;
				end
			end
			default: begin
				state_d = stsu_pkg::ST_ACC;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stsu_pkg::ST_ACC;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	`STSU_ASSERT_NEXT(a_last_stops_input, in_valid && in_ready && last, !in_ready)
	`STSU_ASSERT(a_finish_needs_last, $rose(state_q == stsu_pkg::ST_MUL) |-> $past(accept && last))
	`STSU_ASSERT(a_step_bound, cnt_q <= stsu_pkg::STEP_W'(stsu_pkg::DIV_STEPS))

endmodule
`default_nettype wire

// ===== sv/stsu_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "scan_timing_statistics_unit_macros.svh"
// ----------------------------------------------------------------------------
// stsu_dp
// accumulators, shared 32x32 multiplier, restoring divider, bit-pair sqrt
// ----------------------------------------------------------------------------
module stsu_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stsu_pkg::cmd_t                cmd,
	output stsu_pkg::stat_t               st,
	input  logic                          cfg_we,
	input  logic [stsu_pkg::TIME_W-1:0]   cfg_data,
	input  logic [stsu_pkg::TIME_W-1:0]   scan_time,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [stsu_pkg::CNT_W-1:0]    sample_count,
	output logic [stsu_pkg::TIME_W-1:0]   min_time,
	output logic [stsu_pkg::TIME_W-1:0]   max_time,
	output logic [stsu_pkg::TIME_W-1:0]   mean_time,
	output logic [stsu_pkg::TIME_W-1:0]   std_dev_time,
	output logic [stsu_pkg::CNT_W-1:0]    late_count,
	output logic                          healthy,
	output logic                          overflowed
);

	// configuration
	logic [stsu_pkg::TIME_W-1:0] period_q;

	// running accumulators
	logic [stsu_pkg::CNT_W-1:0]  count_q, ovr_q;
	logic [stsu_pkg::TIME_W-1:0] min_q, max_q;
	logic [stsu_pkg::SUM_W-1:0]  sum_q;
	logic [stsu_pkg::SQ_W-1:0]   sumsq_q;
	logic                        ovf_q;

	logic [stsu_pkg::CNT_W-1:0]  count_d, ovr_d;
	logic [stsu_pkg::TIME_W-1:0] min_d, max_d, t;
	logic [stsu_pkg::SUM_W-1:0]  sum_d;
	logic [stsu_pkg::SQ_W-1:0]   sumsq_d;
	logic                        ovf_d, room, first;

	// snapshot of a finished set
	logic [stsu_pkg::CNT_W-1:0]  n_q, sovr_q;
	logic [stsu_pkg::TIME_W-1:0] smin_q, smax_q, mean_q;
	logic [stsu_pkg::SUM_W-1:0]  ssum_q;
	logic [stsu_pkg::SQ_W-1:0]   ssq_q;
	logic                        sovf_q;

	// partial products
	logic [stsu_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic [stsu_pkg::PROD_W-1:0] prod_s1;
	stsu_pkg::mop_t              op_s1;
	logic                        vld_s1;
	logic [stsu_pkg::D_W-1:0]    d_q;
	logic [stsu_pkg::NSQ_W-1:0]  nsq_q;

	// divider
	logic [stsu_pkg::NSQ_W-1:0]  rem_q, dvs_q;
	logic [stsu_pkg::D_W-1:0]    quo_q;
	logic [stsu_pkg::NSQ_W:0]    trial;
	logic                        div_ge;

	// square root
	logic [stsu_pkg::SQ_W-1:0]   v_q, res_q, sbit_q, trial_s;
	logic                        sq_ge;

	// health terms
	logic [stsu_pkg::TIME_W-1:0] jitter;
	logic [stsu_pkg::JIT_W-1:0]  jit_scaled;
	logic [stsu_pkg::OVR_W-1:0]  ovr_scaled;
	logic                        healthy_d;

	// result register
	logic                        out_valid_q;
	logic [stsu_pkg::CNT_W-1:0]  res_cnt_q, res_ovr_q;
	logic [stsu_pkg::TIME_W-1:0] res_min_q, res_max_q, res_mean_q, res_std_q;
	logic                        res_healthy_q, res_ovf_q;

	// ---------------- accumulation ----------------
	always_comb begin
		t       = scan_time & stsu_pkg::TIME_MASK;
		room    = (count_q < stsu_pkg::CNT_W'(stsu_pkg::MAX_SAMPLES));
		first   = (count_q == '0);
		count_d = count_q;
		min_d   = min_q;
		max_d   = max_q;
		sum_d   = sum_q;
		sumsq_d = sumsq_q;
		ovr_d   = ovr_q;
		ovf_d   = ovf_q;
		if (room) begin
			min_d   = (first || t < min_q) ? t : min_q;
			max_d   = (first || t > max_q) ? t : max_q;
			sum_d   = sum_q + stsu_pkg::SUM_W'(t);
			sumsq_d = sumsq_q + stsu_pkg::SQ_W'(t) * stsu_pkg::SQ_W'(t);
			ovr_d   = ovr_q + stsu_pkg::CNT_W'(t > period_q);
			count_d = count_q + stsu_pkg::CNT_W'(1);
		end else begin
			ovf_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= stsu_pkg::PERIOD_RESET;
			count_q  <= '0;
			min_q    <= '0;
			max_q    <= '0;
			sum_q    <= '0;
			sumsq_q  <= '0;
			ovr_q    <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_data;
			end
			if (cmd.snap) begin
				count_q <= '0;
				min_q   <= '0;
				max_q   <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
				ovr_q   <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.acc_en) begin
				count_q <= count_d;
				min_q   <= min_d;
				max_q   <= max_d;
				sum_q   <= sum_d;
				sumsq_q <= sumsq_d;
				ovr_q   <= ovr_d;
				ovf_q   <= ovf_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			n_q    <= count_d;
			smin_q <= min_d;
			smax_q <= max_d;
			ssum_q <= sum_d;
			ssq_q  <= sumsq_d;
			sovr_q <= ovr_d;
			sovf_q <= ovf_d;
		end
	end

	// ---------------- partial products ----------------
	// d = n*sumsq - sum^2, sum split as hi*2^32 + lo
	always_comb begin
		case (cmd.mul_op)
			stsu_pkg::MOP_NSQ_LO: begin
				mul_a = stsu_pkg::MUL_W'(n_q);
				mul_b = ssq_q[stsu_pkg::MUL_W-1:0];
			end
			stsu_pkg::MOP_NSQ_HI: begin
				mul_a = stsu_pkg::MUL_W'(n_q);
				mul_b = ssq_q[stsu_pkg::SQ_W-1:stsu_pkg::MUL_W];
			end
			stsu_pkg::MOP_LL: begin
				mul_a = ssum_q[stsu_pkg::MUL_W-1:0];
				mul_b = ssum_q[stsu_pkg::MUL_W-1:0];
			end
			stsu_pkg::MOP_HL: begin
				mul_a = stsu_pkg::MUL_W'(ssum_q[stsu_pkg::SUM_W-1:stsu_pkg::MUL_W]);
				mul_b = ssum_q[stsu_pkg::MUL_W-1:0];
			end
			stsu_pkg::MOP_HH: begin
				mul_a = stsu_pkg::MUL_W'(ssum_q[stsu_pkg::SUM_W-1:stsu_pkg::MUL_W]);
				mul_b = stsu_pkg::MUL_W'(ssum_q[stsu_pkg::SUM_W-1:stsu_pkg::MUL_W]);
			end
			stsu_pkg::MOP_NN: begin
				mul_a = stsu_pkg::MUL_W'(n_q);
				mul_b = stsu_pkg::MUL_W'(n_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= stsu_pkg::PROD_W'(mul_a) * stsu_pkg::PROD_W'(mul_b);
		op_s1   <= cmd.mul_op;
		if (vld_s1) begin
			case (op_s1)
				stsu_pkg::MOP_NSQ_LO: d_q   <= stsu_pkg::D_W'(prod_s1);
				stsu_pkg::MOP_NSQ_HI: d_q   <= d_q + stsu_pkg::D_W'({prod_s1, 32'd0});
				stsu_pkg::MOP_LL:     d_q   <= d_q - stsu_pkg::D_W'(prod_s1);
				stsu_pkg::MOP_HL:     d_q   <= d_q - stsu_pkg::D_W'({prod_s1, 33'd0});
				stsu_pkg::MOP_HH:     d_q   <= d_q - stsu_pkg::D_W'({prod_s1, 64'd0});
				stsu_pkg::MOP_NN:     nsq_q <= stsu_pkg::NSQ_W'(prod_s1);
				default:              d_q   <= d_q;
			endcase
		end
	end

	// ---------------- restoring divider, one quotient bit a cycle ----------------
	assign trial  = {rem_q, quo_q[stsu_pkg::D_W-1]};
	assign div_ge = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load_mean) begin
			rem_q <= '0;
			quo_q <= stsu_pkg::D_W'(ssum_q);
			dvs_q <= stsu_pkg::NSQ_W'(n_q);
		end else if (cmd.div_load_var) begin
			mean_q <= quo_q[stsu_pkg::TIME_W-1:0];
			rem_q  <= '0;
			quo_q  <= d_q;
			dvs_q  <= nsq_q;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? stsu_pkg::NSQ_W'(trial - {1'b0, dvs_q})
			                : stsu_pkg::NSQ_W'(trial);
			quo_q <= {quo_q[stsu_pkg::D_W-2:0], div_ge};
		end
	end

	// ---------------- integer square root, two bits a cycle ----------------
	assign trial_s = res_q + sbit_q;
	assign sq_ge   = (v_q >= trial_s);

	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			v_q    <= quo_q[stsu_pkg::SQ_W-1:0];
			res_q  <= '0;
			sbit_q <= stsu_pkg::SQRT_BIT0;
		end else if (cmd.sqrt_step) begin
			if (sq_ge) begin
				v_q   <= v_q - trial_s;
				res_q <= (res_q >> 1) + sbit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	// ---------------- health and result register ----------------
	always_comb begin
		jitter     = smax_q - smin_q;
		jit_scaled = stsu_pkg::JIT_W'(jitter) * stsu_pkg::JIT_W'(stsu_pkg::JITTER_SCALE);
		ovr_scaled = stsu_pkg::OVR_W'(sovr_q) * stsu_pkg::OVR_W'(stsu_pkg::OVERRUN_SCALE);
		healthy_d  = (period_q != '0) &&
		             (jit_scaled < stsu_pkg::JIT_W'(period_q)) &&
		             (ovr_scaled < stsu_pkg::OVR_W'(n_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_cnt_q     <= n_q;
			res_min_q     <= smin_q;
			res_max_q     <= smax_q;
			res_mean_q    <= mean_q;
			res_std_q     <= res_q[stsu_pkg::TIME_W-1:0];
			res_ovr_q     <= sovr_q;
			res_healthy_q <= healthy_d;
			res_ovf_q     <= sovf_q;
		end
	end

	assign st.out_busy   = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign sample_count  = res_cnt_q;
	assign min_time      = res_min_q;
	assign max_time      = res_max_q;
	assign mean_time     = res_mean_q;
	assign std_dev_time  = res_std_q;
	assign late_count    = res_ovr_q;
	assign healthy       = res_healthy_q;
	assign overflowed    = res_ovf_q;

	`STSU_ASSERT(a_count_cap, count_q <= stsu_pkg::CNT_W'(stsu_pkg::MAX_SAMPLES))
	`STSU_ASSERT(a_min_le_max, (count_q != '0) |-> (min_q <= max_q))
	`STSU_ASSERT_NEXT(a_snap_clears, cmd.snap, count_q == '0 && ovf_q == 1'b0)

endmodule
`default_nettype wire

// ===== sv/scan_timing_statistics_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scan_timing_statistics_unit
// per-set count, min, max, mean, std deviation, overruns and health of scan times
// ----------------------------------------------------------------------------
// usage:
// - cfg channel (cfg_valid/cfg_ready/cfg_data) sets the scan period; always
//   ready, write it only while no set is being finished
// - input channel takes one scan_time per cycle while in_ready is high; last closes the set
// - after a transaction with last, in_ready drops while the set is finished:
//   six partial products on one 32x32 multiplier, two 81-bit restoring
//   divisions at one bit per cycle and a 64-bit square root at two bits
//   per cycle
// - the result is registered onto the output channel once the square root
//   is done and the output register is free; in_ready rises with out_valid
// - a held result does not block accumulation of the next set; the next
//   finish waits in its last step until the output register frees up
// - samples past 65536 in a set are dropped and reported by overflowed
// - reset clears all accumulators, drops any pending result and sets
//   the scan period to 250000
// ----------------------------------------------------------------------------
module scan_timing_statistics_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [stsu_pkg::TIME_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [stsu_pkg::TIME_W-1:0] scan_time,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [stsu_pkg::CNT_W-1:0]  sample_count,
	output logic [stsu_pkg::TIME_W-1:0] min_time,
	output logic [stsu_pkg::TIME_W-1:0] max_time,
	output logic [stsu_pkg::TIME_W-1:0] mean_time,
	output logic [stsu_pkg::TIME_W-1:0] std_dev_time,
	output logic [stsu_pkg::CNT_W-1:0]  late_count,
	output logic                        healthy,
	output logic                        overflowed
);

	stsu_pkg::cmd_t  cmd;
	stsu_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	stsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	stsu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.scan_time     (scan_time),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.sample_count  (sample_count),
		.min_time      (min_time),
		.max_time      (max_time),
		.mean_time     (mean_time),
		.std_dev_time  (std_dev_time),
		.late_count    (late_count),
		.healthy       (healthy),
		.overflowed    (overflowed)
	);

endmodule
`default_nettype wire
